/* design/uer_pkg.sv */
`default_nettype none

package uer_pkg;

	localparam int unsigned TICK_W    = 18;
	localparam int unsigned RANGE_W   = 11;
	localparam int unsigned LINES_W   = 10;
	localparam int unsigned SENSOR_W  = 4;
	localparam int unsigned PULSE_W   = 4;
	localparam int unsigned DIST_W    = 10;

	localparam logic [PULSE_W-1:0] PULSE_TICKS = 4'd10;
	localparam int unsigned CM_DIV        = 58;
	localparam int unsigned INCH_DIV      = 148;
	localparam int unsigned NO_ECHO_LIMIT = 5000;
	localparam int unsigned RANGE_MAX     = 2047;

	// ceil(2^24 / d); exact quotient for every 18-bit dividend
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned RECIP_W     = 19;
	localparam int unsigned CM_RECIP    = 289263;
	localparam int unsigned INCH_RECIP  = 113360;

	localparam logic REG_UNITS    = 1'b0;
	localparam logic REG_MAX_DIST = 1'b1;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_ECHO  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_MEASURING = 2'd0,
		ST_DONE      = 2'd1,
		ST_ECHO_LONG = 2'd2,
		ST_NO_ECHO   = 2'd3
	} status_t;

	typedef struct packed {
		logic              use_cm;
		logic [TICK_W-1:0] width;
	} div_req_t;

endpackage

`default_nettype wire

/* design/uer_range_div.sv */
`default_nettype none

module uer_range_div
	import uer_pkg::*;
(
	input  div_req_t             req,
	output logic [RANGE_W-1:0]   range
);

	localparam int unsigned PROD_W = TICK_W + RECIP_W;
	localparam int unsigned QUOT_W = PROD_W - RECIP_SHIFT;

	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0]  prod;
	logic [QUOT_W-1:0]  quot;

	// reciprocal multiply stands in for the divide by 58 or 148
	assign recip = req.use_cm ? RECIP_W'(CM_RECIP) : RECIP_W'(INCH_RECIP);
	assign prod  = PROD_W'(req.width) * PROD_W'(recip);
	assign quot  = prod[PROD_W-1:RECIP_SHIFT];

	always_comb begin
		if (quot > QUOT_W'(RANGE_MAX)) begin
			range = RANGE_W'(RANGE_MAX);
		end else begin
			range = quot[RANGE_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* design/ultrasonic_echo_ranger_unit.sv */
// channel   dir  fields (low bit up)                          beat
// s_axis    in   tuser: command[1:0]; tdata: sensor[3:0],     tvalid & tready
//                echo_level[4]
// m_axis    out  tdata: status[1:0], range[12:2],             tvalid & tready
//                trigger_lines[22:13]
// apb       in   reg 0 use_centimetres @0x0, reg 1 max_distance @0x4
//
// One item per cycle while the output is not stalled; each result is registered in s1 and then in the output register.
// Controller state updates at the input beat; the range divide (one
// reciprocal multiply) sits between the s1 register and the output register.
// Reset sets the block idle with measured width 0, centimetres, limit 400.
// A stalled output holds its beat; the input keeps accepting until both
// stages are full.
`default_nettype none

module ultrasonic_echo_ranger_unit
	import uer_pkg::*;
#(
	parameter int unsigned NUM_SENSORS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_axis_tdata: sensor[3:0], echo_level[4], zero[7:5]
	input  wire logic [7:0]  s_axis_tdata,
	// s_axis_tuser: command[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// m_axis_tdata: status[1:0], range[12:2], trigger_lines[22:13], zero[23]
	output logic [23:0]      m_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic              use_cm_q;
	logic [DIST_W-1:0] max_dist_q;

	logic                fin_q, fin_d;
	logic                echo_q, echo_d;
	logic [PULSE_W-1:0]  ptl_q, ptl_d;
	logic [SENSOR_W-1:0] sel_q, sel_d;
	logic [TICK_W-1:0]   elapsed_q, elapsed_d;
	logic [TICK_W-1:0]   width_q, width_d;

	logic                counting;
	logic [TICK_W-1:0]   elapsed_inc;
	logic [TICK_W-1:0]   limit;
	logic                tout;
	status_t             tout_st;
	status_t             status_d;
	logic [LINES_W-1:0]  lines_d;

	cmd_t                cmd;
	logic [SENSOR_W-1:0] sensor;
	logic                echo_level;
	logic                in_fire;
	logic                out_load;
	logic                cfg_wr;

	logic                valid_s1;
	status_t             status_s1;
	logic [LINES_W-1:0]  lines_s1;
	div_req_t            req_s1;

	logic                valid_s2;
	status_t             status_s2;
	logic [RANGE_W-1:0]  range_s2;
	logic [LINES_W-1:0]  lines_s2;
	logic [RANGE_W-1:0]  range_s1;

	assign cmd        = cmd_t'(s_axis_tuser);
	assign sensor     = s_axis_tdata[SENSOR_W-1:0];
	assign echo_level = s_axis_tdata[SENSOR_W];

	assign out_load      = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_load;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_cm_q   <= 1'b1;
			max_dist_q <= DIST_W'(400);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_UNITS:    use_cm_q   <= pwdata[0];
				REG_MAX_DIST: max_dist_q <= pwdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_UNITS:    prdata = {31'b0, use_cm_q};
			REG_MAX_DIST: prdata = {{(32-DIST_W){1'b0}}, max_dist_q};
			default:      prdata = '0;
		endcase
	end

	assign limit = TICK_W'(max_dist_q) * TICK_W'(use_cm_q ? CM_DIV : INCH_DIV);

	// controller next state
	assign counting    = !fin_q && ((ptl_q == '0) || echo_q);
	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;

	always_comb begin
		fin_d     = fin_q;
		echo_d    = echo_q;
		ptl_d     = ptl_q;
		sel_d     = sel_q;
		elapsed_d = elapsed_q;
		width_d   = width_q;
		tout      = 1'b0;
		tout_st   = ST_NO_ECHO;
		unique case (cmd)
			CMD_TICK: begin
				if (ptl_q != '0) begin
					ptl_d = ptl_q - 1'b1;
				end
				if (counting) begin
					elapsed_d = elapsed_inc;
					if (echo_q) begin
						if (elapsed_inc > limit) begin
							fin_d   = 1'b1;
							echo_d  = 1'b0;
							tout    = 1'b1;
							tout_st = ST_ECHO_LONG;
						end
					end else if ((ptl_d == '0) && (elapsed_inc > TICK_W'(NO_ECHO_LIMIT))) begin
						fin_d   = 1'b1;
						tout    = 1'b1;
						tout_st = ST_NO_ECHO;
					end
				end
			end
			CMD_START: begin
				if (32'(sensor) < NUM_SENSORS) begin
					sel_d     = sensor;
					ptl_d     = PULSE_TICKS;
					fin_d     = 1'b0;
					echo_d    = 1'b0;
					elapsed_d = '0;
				end
			end
			CMD_ECHO: begin
				if (echo_level) begin
					if (!fin_q) begin
						echo_d    = 1'b1;
						elapsed_d = '0;
					end
				end else if (echo_q) begin
					width_d = elapsed_q;
					echo_d  = 1'b0;
					fin_d   = 1'b1;
				end
			end
			CMD_NONE: ;
			default: ;
		endcase

		if (tout) begin
			status_d = tout_st;
		end else begin
			status_d = fin_d ? ST_DONE : ST_MEASURING;
		end

		if (ptl_d != '0) begin
			lines_d = LINES_W'(16'b1 << sel_d);
		end else begin
			lines_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q     <= 1'b1;
			echo_q    <= 1'b0;
			ptl_q     <= '0;
			sel_q     <= '0;
			elapsed_q <= '0;
			width_q   <= '0;
		end else if (in_fire) begin
			fin_q     <= fin_d;
			echo_q    <= echo_d;
			ptl_q     <= ptl_d;
			sel_q     <= sel_d;
			elapsed_q <= elapsed_d;
			width_q   <= width_d;
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (out_load) begin
				valid_s1 <= 1'b0;
			end
			if (out_load) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_s1     <= status_d;
			lines_s1      <= lines_d;
			req_s1.use_cm <= use_cm_q;
			req_s1.width  <= width_d;
		end
		if (out_load && valid_s1) begin
			status_s2 <= status_s1;
			range_s2  <= range_s1;
			lines_s2  <= lines_s1;
		end
	end

	uer_range_div u_div (
		.req   (req_s1),
		.range (range_s1)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, lines_s2, range_s2, status_s2};

endmodule

`default_nettype wire

/* design/uer_checker.sv */
`default_nettype none

module uer_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output empty");

	// at most one trigger line drives at a time
	a_trigger_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0(m_axis_tdata[22:13]))
		else $error("more than one trigger line high");

	// an accepted beat with the output stage empty leads to a valid output after the s1 and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
		else $error("result missing after accepted beat");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

`default_nettype wire
